// ----- sv/adcss_pkg.sv -----
// Shared types and constants for the ADC scan sequencer.
`timescale 1ns / 1ps

package adcss_pkg;

    // Field widths
    localparam int OP_W      = 2;
    localparam int CH_W      = 4;
    localparam int WORD_W    = 32;
    localparam int CMD_W     = 3;
    localparam int GAIN_W    = 8;
    localparam int CODE_W    = 4;
    localparam int CNT_W     = 16;
    localparam int CCOUNT_W  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Configuration register reset values
    localparam logic [CCOUNT_W-1:0] RST_CHANNEL_COUNT = 5'd16;
    localparam logic [CNT_W-1:0]    RST_SETTLE_TICKS  = 16'd6;
    localparam logic [CNT_W-1:0]    RST_READ_TIMEOUT  = 16'd20;
    localparam logic [CODE_W-1:0]   RST_CURRENT_GAIN  = 4'd2;
    localparam logic [CODE_W-1:0]   RST_VOLTAGE_GAIN  = 4'd1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 3'd0,
        REG_SETTLE_TICKS  = 3'd1,
        REG_READ_TIMEOUT  = 3'd2,
        REG_CURRENT_GAIN  = 3'd3,
        REG_VOLTAGE_GAIN  = 3'd4
    } reg_idx_t;

    // Request operations
    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_ENTER_HOLD = 2'd1,
        OP_LEAVE_HOLD = 2'd2
    } op_t;

    // Result commands
    typedef enum logic [CMD_W-1:0] {
        CMD_NONE    = 3'd0,
        CMD_IDLE    = 3'd1,
        CMD_GAIN    = 3'd2,
        CMD_START_I = 3'd3,
        CMD_START_V = 3'd4,
        CMD_RELEASE = 3'd5
    } cmd_t;

    // Sequencer phases, one-hot
    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_GAIN    = 9'b000000010,
        PH_SETTLE  = 9'b000000100,
        PH_TRIG_I  = 9'b000001000,
        PH_READ_I  = 9'b000010000,
        PH_TRIG_V  = 9'b000100000,
        PH_READ_V  = 9'b001000000,
        PH_NEXT    = 9'b010000000,
        PH_STOPPED = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [CCOUNT_W-1:0] channel_count;
        logic [CNT_W-1:0]    settle_ticks;
        logic [CNT_W-1:0]    read_timeout;
        logic [CODE_W-1:0]   current_gain_code;
        logic [CODE_W-1:0]   voltage_gain_code;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CH_W-1:0]   hold_channel;
        logic              data_ready;
        logic [WORD_W-1:0] adc_word;
    } in_item_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CH_W-1:0]   channel;
        logic [GAIN_W-1:0] gain_word;
        logic [WORD_W-1:0] sample_value;
        logic              store_current;
        logic              store_voltage;
        logic              adc_reset;
    } result_t;

endpackage

// ----- sv/adcss_in_stage.sv -----
// Input request register of the ADC scan sequencer.
`timescale 1ns / 1ps

module adcss_in_stage
    import adcss_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output logic     item_valid,
    input  logic     item_take,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Take a new request when empty or when the held one moves on this cycle
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- sv/adcss_seq.sv -----
// Sequencer state and combinational step logic of the ADC scan sequencer.
`timescale 1ns / 1ps

module adcss_seq
    import adcss_pkg::*;
#(
    parameter int MAX_CHANNELS = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     step_en,
    input  in_item_t item,
    output result_t  result
);

    localparam int MaxW = $clog2(MAX_CHANNELS + 1);
    localparam int LimW = (MaxW > CCOUNT_W) ? MaxW : CCOUNT_W;
    localparam logic [LimW-1:0] MaxLim = LimW'(MAX_CHANNELS);

    phase_t            phase_reg,    phase_next;
    logic [CH_W-1:0]   scan_reg,     scan_next;
    logic [CNT_W-1:0]  settle_reg,   settle_next;
    logic [CNT_W-1:0]  wait_reg,     wait_next;
    logic              hold_reg,     hold_next;
    logic [CH_W-1:0]   held_reg,     held_next;

    logic [CNT_W:0]    settle_inc;
    logic [CNT_W:0]    wait_inc;
    logic              late;
    logic [LimW-1:0]   cnt_ext;
    logic [LimW-1:0]   lim;
    logic [LimW-1:0]   ch_inc;
    logic [CH_W-1:0]   ch_wrap;
    logic              store_ok;

    // Counter increments and scan wrap
    assign settle_inc = {1'b0, settle_reg} + 1'b1;
    assign wait_inc   = {1'b0, wait_reg} + 1'b1;
    assign late       = wait_inc > {1'b0, cfg.read_timeout};
    assign cnt_ext    = LimW'(cfg.channel_count);
    assign lim        = (cnt_ext < MaxLim) ? cnt_ext : MaxLim;
    assign ch_inc     = LimW'(scan_reg) + 1'b1;
    assign ch_wrap    = (ch_inc >= lim) ? '0 : ch_inc[CH_W-1:0];
    assign store_ok   = item.data_ready && (item.adc_word != '0);

    // Next state and result for one request
    always_comb begin
        phase_next  = phase_reg;
        scan_next   = scan_reg;
        settle_next = settle_reg;
        wait_next   = wait_reg;
        hold_next   = hold_reg;
        held_next   = held_reg;
        result      = '0;
        result.command = CMD_NONE;

        unique case (op_t'(item.operation))
            OP_ENTER_HOLD: begin
                held_next = item.hold_channel;
                hold_next = 1'b1;
            end
            OP_LEAVE_HOLD: begin
                hold_next  = 1'b0;
                phase_next = PH_IDLE;
            end
            OP_TICK: begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        result.command = CMD_IDLE;
                        scan_next   = '0;
                        settle_next = '0;
                        phase_next  = PH_GAIN;
                    end
                    PH_GAIN: begin
                        if (hold_reg) begin
                            scan_next  = held_reg;
                            phase_next = PH_STOPPED;
                        end else begin
                            phase_next = PH_SETTLE;
                        end
                        result.command   = CMD_GAIN;
                        result.gain_word = {cfg.current_gain_code, cfg.voltage_gain_code};
                        settle_next      = '0;
                    end
                    PH_SETTLE: begin
                        settle_next = settle_inc[CNT_W] ? CNT_MAX : settle_inc[CNT_W-1:0];
                        if (settle_inc >= {1'b0, cfg.settle_ticks}) begin
                            phase_next  = PH_TRIG_I;
                            settle_next = '0;
                        end
                    end
                    PH_TRIG_I: begin
                        result.command = CMD_START_I;
                        wait_next  = '0;
                        phase_next = PH_READ_I;
                    end
                    PH_TRIG_V: begin
                        result.command = CMD_START_V;
                        wait_next  = '0;
                        phase_next = PH_READ_V;
                    end
                    PH_READ_I, PH_READ_V: begin
                        if (store_ok) begin
                            result.sample_value  = item.adc_word;
                            result.store_current = (phase_reg == PH_READ_I);
                            result.store_voltage = (phase_reg == PH_READ_V);
                        end
                        wait_next = wait_inc[CNT_W] ? CNT_MAX : wait_inc[CNT_W-1:0];
                        result.adc_reset = late;
                        if (item.data_ready || late) begin
                            result.command = CMD_RELEASE;
                            phase_next = (phase_reg == PH_READ_I) ? PH_TRIG_V : PH_NEXT;
                        end
                    end
                    PH_NEXT: begin
                        if (!hold_reg) begin
                            scan_next = ch_wrap;
                        end
                        phase_next = PH_GAIN;
                    end
                    PH_STOPPED: begin
                        phase_next = PH_STOPPED;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default: begin
                // unused operation code: no change
                phase_next = phase_reg;
            end
        endcase

        result.channel = scan_next;
    end

    // State registers advance once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            scan_reg   <= '0;
            settle_reg <= '0;
            wait_reg   <= '0;
            hold_reg   <= 1'b0;
            held_reg   <= '0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            scan_reg   <= scan_next;
            settle_reg <= settle_next;
            wait_reg   <= wait_next;
            hold_reg   <= hold_next;
            held_reg   <= held_next;
        end
    end

endmodule

// ----- sv/adcss_out_stage.sv -----
// Result register of the ADC scan sequencer.
`timescale 1ns / 1ps

module adcss_out_stage
    import adcss_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    output logic    can_load,
    input  result_t result,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Register is free when empty or being drained this cycle
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ----- sv/adc_scan_sequencer_unit.sv -----
// Top level of the ADC scan sequencer: config registers and stage wiring.
`timescale 1ns / 1ps

// Round-robin current/voltage ADC scan sequencer. Each request (a timer tick,
// enter hold or leave hold) yields exactly one result carrying the command to
// issue, the active channel, the gain word and any sample to store. One request
// is accepted per cycle unless m_ready stalls the result register; its result
// passes the input and result registers, the whole step being combinational
// logic between them. The config port is always ready and must only be written
// while no request is in flight. MAX_CHANNELS caps the channel wrap limit.
module adc_scan_sequencer_unit
    import adcss_pkg::*;
#(
    parameter int MAX_CHANNELS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_operation,
    input  logic [CH_W-1:0]      s_hold_channel,
    input  logic                 s_data_ready,
    input  logic [WORD_W-1:0]    s_adc_word,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CMD_W-1:0]     m_command,
    output logic [CH_W-1:0]      m_channel,
    output logic [GAIN_W-1:0]    m_gain_word,
    output logic [WORD_W-1:0]    m_sample_value,
    output logic                 m_store_current,
    output logic                 m_store_voltage,
    output logic                 m_adc_reset
);

    cfg_t     cfg_reg;
    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     can_load;
    logic     step;
    result_t  result;
    result_t  out_result;

    // Config register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_count     <= RST_CHANNEL_COUNT;
            cfg_reg.settle_ticks      <= RST_SETTLE_TICKS;
            cfg_reg.read_timeout      <= RST_READ_TIMEOUT;
            cfg_reg.current_gain_code <= RST_CURRENT_GAIN;
            cfg_reg.voltage_gain_code <= RST_VOLTAGE_GAIN;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_idx_t'(cfg_index))
                REG_CHANNEL_COUNT: cfg_reg.channel_count     <= cfg_data[CCOUNT_W-1:0];
                REG_SETTLE_TICKS:  cfg_reg.settle_ticks      <= cfg_data[CNT_W-1:0];
                REG_READ_TIMEOUT:  cfg_reg.read_timeout      <= cfg_data[CNT_W-1:0];
                REG_CURRENT_GAIN:  cfg_reg.current_gain_code <= cfg_data[CODE_W-1:0];
                REG_VOLTAGE_GAIN:  cfg_reg.voltage_gain_code <= cfg_data[CODE_W-1:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Input request register
    assign in_item.operation    = s_operation;
    assign in_item.hold_channel = s_hold_channel;
    assign in_item.data_ready   = s_data_ready;
    assign in_item.adc_word     = s_adc_word;

    adcss_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (step),
        .item       (item)
    );

    // Step when a request is held and the result register can take its result
    assign step = item_valid && can_load;

    adcss_seq #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .step_en (step),
        .item    (item),
        .result  (result)
    );

    adcss_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (step),
        .can_load   (can_load),
        .result     (result),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (out_result)
    );

    assign m_command       = out_result.command;
    assign m_channel       = out_result.channel;
    assign m_gain_word     = out_result.gain_word;
    assign m_sample_value  = out_result.sample_value;
    assign m_store_current = out_result.store_current;
    assign m_store_voltage = out_result.store_voltage;
    assign m_adc_reset     = out_result.adc_reset;

endmodule
